### hdl/ofdm_eq_pkg.sv
package ofdm_eq_pkg;

  // Field widths
  localparam int SampleW  = 16;
  localparam int ProdW    = 32;
  localparam int MantW    = 15;
  localparam int ExpW     = 7;
  localparam int ScaleW   = 4;
  localparam int NormW    = 5;
  localparam int NormMinW = 6;
  localparam int AccW     = ProdW + 1;

  // Reset values
  localparam logic [ScaleW-1:0]   SOFT_SCALE_RESET = 4'd6;
  localparam logic [NormMinW-1:0] NORM_MIN_RESET   = 6'd32;

  // Fixed part of the output shift: 14 + 16
  localparam logic signed [8:0] SHIFT_BASE = 9'sd30;
  localparam logic [4:0]        SHIFT_MAX  = 5'd31;

  // Multiply-accumulate operations
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_NRE,
    S_NIM,
    S_MRE,
    S_MIM,
    S_OUT
  } eq_state_t;

endpackage

### hdl/ofdm_eq_mac.sv
// Shared signed 16x16 multiplier with a 33-bit accumulator
module ofdm_eq_mac (
  input  logic                                   clk,
  input  ofdm_eq_pkg::mac_op_t                   op,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0] a,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0] b,
  output logic signed [ofdm_eq_pkg::AccW-1:0]    acc
);

  logic signed [ofdm_eq_pkg::ProdW-1:0] prod;
  logic signed [ofdm_eq_pkg::AccW-1:0]  prod_ext;

  assign prod     = a * b;
  assign prod_ext = {prod[ofdm_eq_pkg::ProdW-1], prod};

  // Accumulator update
  always_ff @(posedge clk) begin
    case (op)
      ofdm_eq_pkg::MAC_LOAD: acc <= prod_ext;
      ofdm_eq_pkg::MAC_ADD:  acc <= acc + prod_ext;
      ofdm_eq_pkg::MAC_SUB:  acc <= acc - prod_ext;
      default:               acc <= acc;
    endcase
  end

endmodule

### hdl/ofdm_eq_norm.sv
// Iterative sign-bit normalizer: binary search in five steps (16, 8, 4, 2, 1).
// Gives the redundant sign bit count and the value shifted left by it.
module ofdm_eq_norm (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  logic [ofdm_eq_pkg::ProdW-1:0]        din,
  output logic                                 done,
  output logic [ofdm_eq_pkg::NormW-1:0]        count,
  output logic [ofdm_eq_pkg::SampleW-1:0]      high
);

  logic                          busy;
  logic [2:0]                    step;
  logic [ofdm_eq_pkg::ProdW-1:0] x;
  logic [4:0]                    k;
  logic [5:0]                    k_plus;
  logic [ofdm_eq_pkg::ProdW-1:0] mask;
  logic [ofdm_eq_pkg::ProdW-1:0] diff;
  logic                          hit;

  // Test whether the top k+1 bits all match the sign
  assign k      = 5'd16 >> step;
  assign k_plus = {1'b0, k} + 6'd1;
  assign mask   = ~({ofdm_eq_pkg::ProdW{1'b1}} >> k_plus);
  assign diff   = x ^ {ofdm_eq_pkg::ProdW{x[ofdm_eq_pkg::ProdW-1]}};
  assign hit    = (diff & mask) == '0;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd4) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (load) begin
      x     <= din;
      count <= '0;
    end else if (busy && hit) begin
      x     <= x << k;
      count <= count + k;
    end
  end

  assign done = ~busy;
  assign high = x[ofdm_eq_pkg::ProdW-1 -: ofdm_eq_pkg::SampleW];

endmodule

### hdl/ofdm_channel_equalizer_fixed.sv
// OFDM zero-forcing equalizer, fixed point, one subcarrier per request.
// Input channel (in_valid/in_ready) carries y, conj(h), the reciprocal of
// |h|^2 as mantissa and exponent, and last_in. Output channel
// (out_valid/out_ready) carries the equalized point, y*conj(h), the running
// minimum of sign-bit counts and last_out.
// One shared 16x16 multiplier forms the four partial products, then the two
// mantissa products; an iterative normalizer handles each part in turn.
// The block takes one request at a time: it accepts no new request until
// it is through with the last. A finished result sits in the output register,
// and the next request is accepted while it waits. If the receiver stalls
// until the next result is ready, the block holds that second result until
// the register frees. soft_scale is written through cfg_we/cfg_wdata; the
// user must do so only while idle, the block itself does not enforce it.
// Reset (rst, synchronous) empties the block, sets soft_scale to 6 and the
// running minimum to 32; the minimum returns to 32 after each last_in item.
module ofdm_channel_equalizer_fixed (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_we,
  input  logic [ofdm_eq_pkg::ScaleW-1:0]                cfg_wdata,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0]        y_re,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0]        y_im,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0]        hconj_re,
  input  logic signed [ofdm_eq_pkg::SampleW-1:0]        hconj_im,
  input  logic [ofdm_eq_pkg::MantW-1:0]                 recip_mant,
  input  logic signed [ofdm_eq_pkg::ExpW-1:0]           recip_exp,
  input  logic                                          last_in,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic signed [ofdm_eq_pkg::SampleW-1:0]        eq_re,
  output logic signed [ofdm_eq_pkg::SampleW-1:0]        eq_im,
  output logic signed [ofdm_eq_pkg::ProdW-1:0]          prod_re,
  output logic signed [ofdm_eq_pkg::ProdW-1:0]          prod_im,
  output logic [ofdm_eq_pkg::NormMinW-1:0]              headroom_min,
  output logic                                          last_out
);

  ofdm_eq_pkg::eq_state_t state, state_next;

  logic [ofdm_eq_pkg::ScaleW-1:0]         soft_scale;
  logic [ofdm_eq_pkg::NormMinW-1:0]       running_min;

  // Captured request
  logic signed [ofdm_eq_pkg::SampleW-1:0] yr, yi, hr, hi;
  logic [ofdm_eq_pkg::MantW-1:0]          mant;
  logic signed [ofdm_eq_pkg::ExpW-1:0]    ex;
  logic                                   last;

  // Intermediate results
  logic signed [ofdm_eq_pkg::ProdW-1:0]   pr, pi;
  logic [ofdm_eq_pkg::NormW-1:0]          n_re, n_im;
  logic signed [ofdm_eq_pkg::SampleW-1:0] nh_re, nh_im;
  logic signed [ofdm_eq_pkg::SampleW-1:0] eq_re_hold;

  // Shared units
  ofdm_eq_pkg::mac_op_t                   mac_op;
  logic signed [ofdm_eq_pkg::SampleW-1:0] mac_a, mac_b;
  logic signed [ofdm_eq_pkg::AccW-1:0]    acc;
  logic signed [ofdm_eq_pkg::ProdW-1:0]   acc_sat;
  logic                                   norm_load;
  logic                                   norm_done;
  logic [ofdm_eq_pkg::NormW-1:0]          norm_count;
  logic [ofdm_eq_pkg::SampleW-1:0]        norm_high;

  logic                                   out_free;
  logic [ofdm_eq_pkg::NormW-1:0]          sh_n;
  logic signed [8:0]                      sh_raw;
  logic [4:0]                             sh;
  logic signed [ofdm_eq_pkg::ProdW-1:0]   shifted;
  logic [ofdm_eq_pkg::NormMinW-1:0]       mn_a, mn;

  ofdm_eq_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  ofdm_eq_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .load  (norm_load),
    .din   (acc_sat),
    .done  (norm_done),
    .count (norm_count),
    .high  (norm_high)
  );

  // Accumulator saturated to 32 bits
  always_comb begin
    if (acc[ofdm_eq_pkg::AccW-1] != acc[ofdm_eq_pkg::ProdW-1]) begin
      acc_sat = acc[ofdm_eq_pkg::AccW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      acc_sat = acc[ofdm_eq_pkg::ProdW-1:0];
    end
  end

  // Output shift: 30 + n - soft_scale - exponent, clamped to 0..31
  assign sh_n   = (state == ofdm_eq_pkg::S_MIM) ? n_re : n_im;
  assign sh_raw = ofdm_eq_pkg::SHIFT_BASE + $signed({4'b0, sh_n})
                - $signed({5'b0, soft_scale}) - $signed({{2{ex[6]}}, ex});
  always_comb begin
    if (sh_raw < 0) begin
      sh = '0;
    end else if (sh_raw > $signed({4'b0, ofdm_eq_pkg::SHIFT_MAX})) begin
      sh = ofdm_eq_pkg::SHIFT_MAX;
    end else begin
      sh = sh_raw[4:0];
    end
  end
  assign shifted = $signed(acc[ofdm_eq_pkg::ProdW-1:0]) >>> sh;

  // Running minimum including this item
  assign mn_a = ({1'b0, n_re} < running_min) ? {1'b0, n_re} : running_min;
  assign mn   = ({1'b0, n_im} < mn_a) ? {1'b0, n_im} : mn_a;

  assign out_free = ~out_valid | out_ready;
  assign in_ready = (state == ofdm_eq_pkg::S_IDLE);

  // Sequencer: next state and unit controls
  always_comb begin
    state_next = state;
    mac_op     = ofdm_eq_pkg::MAC_HOLD;
    mac_a      = yr;
    mac_b      = hr;
    norm_load  = 1'b0;
    case (state)
      ofdm_eq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ofdm_eq_pkg::S_P0;
        end
      end
      ofdm_eq_pkg::S_P0: begin
        mac_op     = ofdm_eq_pkg::MAC_LOAD;
        state_next = ofdm_eq_pkg::S_P1;
      end
      ofdm_eq_pkg::S_P1: begin
        mac_op     = ofdm_eq_pkg::MAC_SUB;
        mac_a      = yi;
        mac_b      = hi;
        state_next = ofdm_eq_pkg::S_P2;
      end
      ofdm_eq_pkg::S_P2: begin
        // real part is final: start normalizing it
        norm_load  = 1'b1;
        mac_op     = ofdm_eq_pkg::MAC_LOAD;
        mac_b      = hi;
        state_next = ofdm_eq_pkg::S_P3;
      end
      ofdm_eq_pkg::S_P3: begin
        mac_op     = ofdm_eq_pkg::MAC_ADD;
        mac_a      = yi;
        state_next = ofdm_eq_pkg::S_NRE;
      end
      ofdm_eq_pkg::S_NRE: begin
        if (norm_done) begin
          norm_load  = 1'b1;
          state_next = ofdm_eq_pkg::S_NIM;
        end
      end
      ofdm_eq_pkg::S_NIM: begin
        if (norm_done) begin
          state_next = ofdm_eq_pkg::S_MRE;
        end
      end
      ofdm_eq_pkg::S_MRE: begin
        mac_op     = ofdm_eq_pkg::MAC_LOAD;
        mac_a      = $signed({1'b0, mant});
        mac_b      = nh_re;
        state_next = ofdm_eq_pkg::S_MIM;
      end
      ofdm_eq_pkg::S_MIM: begin
        mac_op     = ofdm_eq_pkg::MAC_LOAD;
        mac_a      = $signed({1'b0, mant});
        mac_b      = nh_im;
        state_next = ofdm_eq_pkg::S_OUT;
      end
      ofdm_eq_pkg::S_OUT: begin
        if (out_free) begin
          state_next = ofdm_eq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ofdm_eq_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofdm_eq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      soft_scale <= ofdm_eq_pkg::SOFT_SCALE_RESET;
    end else if (cfg_we) begin
      soft_scale <= cfg_wdata;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      yr   <= y_re;
      yi   <= y_im;
      hr   <= hconj_re;
      hi   <= hconj_im;
      mant <= recip_mant;
      ex   <= recip_exp;
      last <= last_in;
    end
  end

  // Intermediate captures
  always_ff @(posedge clk) begin
    if (state == ofdm_eq_pkg::S_P2) begin
      pr <= acc_sat;
    end
    if (state == ofdm_eq_pkg::S_NRE && norm_done) begin
      pi    <= acc_sat;
      n_re  <= norm_count;
      nh_re <= norm_high;
    end
    if (state == ofdm_eq_pkg::S_NIM && norm_done) begin
      n_im  <= norm_count;
      nh_im <= norm_high;
    end
    if (state == ofdm_eq_pkg::S_MIM) begin
      eq_re_hold <= shifted[ofdm_eq_pkg::SampleW-1:0];
    end
  end

  // Output register and running minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_min <= ofdm_eq_pkg::NORM_MIN_RESET;
    end else if (state == ofdm_eq_pkg::S_OUT && out_free) begin
      out_valid   <= 1'b1;
      running_min <= last ? ofdm_eq_pkg::NORM_MIN_RESET : mn;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ofdm_eq_pkg::S_OUT && out_free) begin
      eq_re        <= eq_re_hold;
      eq_im        <= shifted[ofdm_eq_pkg::SampleW-1:0];
      prod_re      <= pr;
      prod_im      <= pi;
      headroom_min <= mn;
      last_out     <= last;
    end
  end

endmodule
